/* src/sbus_frame_receiver_core_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the SBUS frame receiver core.
// Each macro assumes clk and arst_n are visible where it is used.
// ---------------------------------------------------------------------------
`ifndef SBUS_FRAME_RECEIVER_CORE_ASSERT_SVH
`define SBUS_FRAME_RECEIVER_CORE_ASSERT_SVH

// Check a property on every rising edge of clk outside of reset.
`define SBUSFR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising edge of clk outside of reset.
`define SBUSFR_ASSERT_NEVER(label, cond, msg) \
	`SBUSFR_ASSERT(label, !(cond), msg)

`endif

/* src/sbusfr_pkg.sv */
// ---------------------------------------------------------------------------
// sbusfr_pkg
// Shared types and constants of the SBUS frame receiver core.
// ---------------------------------------------------------------------------
package sbusfr_pkg;

	localparam logic [7:0] START_BYTE  = 8'h0F;
	localparam int         STORE_BYTES = 23;
	localparam int         STORE_W     = STORE_BYTES * 8;
	localparam int         CHAN_COUNT  = 16;
	localparam int         CHAN_W      = 11;
	localparam int         DATA_W      = CHAN_COUNT * CHAN_W;
	localparam logic [CHAN_W-1:0] CHAN_MASK = 11'h7FF;
	localparam logic [3:0] CHAN_LAST   = 4'(CHAN_COUNT - 1);
	localparam logic [4:0] POS_FIRST   = 5'd1;
	localparam logic [4:0] POS_STORE_LAST = 5'(STORE_BYTES);
	localparam logic [15:0] TIMEOUT_RESET = 16'd100;
	localparam logic [15:0] AGE_MAX    = 16'hFFFF;

	// Input action codes
	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// Configuration register indexes
	localparam logic CFG_TIMEOUT = 1'b0;
	localparam logic CFG_END     = 1'b1;

	// Job queue between front and back: two entries, one-bit pointers wrap
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		LINK_OK      = 2'd0,
		LINK_LOST    = 2'd1,
		LINK_SAFE    = 2'd2,
		LINK_TIMEOUT = 2'd3
	} link_t;

	typedef struct packed {
		logic              is_timeout;
		logic [7:0]        flags;
		link_t             status;
		logic [DATA_W-1:0] chan_bits;
	} job_t;

endpackage

/* src/sbusfr_job_queue.sv */
// ---------------------------------------------------------------------------
// sbusfr_job_queue
// Two-entry queue of decoded jobs between the front and the back.
// ---------------------------------------------------------------------------
`include "sbus_frame_receiver_core_assert.svh"

module sbusfr_job_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sbusfr_pkg::job_t  push_job,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output sbusfr_pkg::job_t  head
);

	sbusfr_pkg::job_t mem_q [sbusfr_pkg::QUEUE_DEPTH];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == 2'(sbusfr_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_job;
	end

	`SBUSFR_ASSERT_NEVER(a_count_bound, count_q > 2'(sbusfr_pkg::QUEUE_DEPTH), "queue overfilled")
	`SBUSFR_ASSERT(a_push_grows, (do_push && !do_pop) |=> (count_q == $past(count_q) + 2'd1), "push lost")
	`SBUSFR_ASSERT(a_ptr_gap, (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q), "pointers out of step")

endmodule

/* src/sbusfr_front.sv */
// ---------------------------------------------------------------------------
// sbusfr_front
// Accepts bytes and ticks, tracks framing, link status and tick age.
// ---------------------------------------------------------------------------
`include "sbus_frame_receiver_core_assert.svh"

module sbusfr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic              accept,
	input  logic              action,
	input  logic [7:0]        data_byte,
	output logic              job_push,
	output sbusfr_pkg::job_t  job
);

	logic [15:0]                    timeout_q;
	logic [7:0]                     end_q;
	logic                           collecting_q;
	logic [4:0]                     pos_q;
	sbusfr_pkg::link_t              status_q;
	logic [15:0]                    age_q;
	logic [sbusfr_pkg::STORE_W-1:0] store_q;

	logic [15:0]       age_next;
	logic              tmo_hit;
	logic              in_range;
	logic              is_tick;
	logic              frame_end;
	logic              frame_ok;
	logic [7:0]        flags;
	sbusfr_pkg::link_t frame_status;

	assign is_tick  = (action == sbusfr_pkg::ACT_TICK);
	assign age_next = (age_q == sbusfr_pkg::AGE_MAX) ? age_q : age_q + 16'd1;
	assign tmo_hit  = (age_next > timeout_q) && (status_q != sbusfr_pkg::LINK_TIMEOUT);
	assign in_range = (pos_q >= sbusfr_pkg::POS_FIRST) && (pos_q <= sbusfr_pkg::POS_STORE_LAST);
	assign frame_end = collecting_q && !in_range;
	assign frame_ok  = frame_end && (data_byte == end_q);
	assign flags     = store_q[sbusfr_pkg::STORE_W-1 -: 8];

	always_comb begin
		if (flags[3])      frame_status = sbusfr_pkg::LINK_SAFE;
		else if (flags[2]) frame_status = sbusfr_pkg::LINK_LOST;
		else               frame_status = sbusfr_pkg::LINK_OK;
	end

	// Hand a job to the back on a timeout tick or a frame with the right end byte
	always_comb begin
		job_push       = accept && (is_tick ? tmo_hit : frame_ok);
		job.is_timeout = is_tick;
		job.flags      = is_tick ? 8'd0 : flags;
		job.status     = is_tick ? sbusfr_pkg::LINK_TIMEOUT : frame_status;
		job.chan_bits  = store_q[sbusfr_pkg::DATA_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q    <= sbusfr_pkg::TIMEOUT_RESET;
			end_q        <= 8'd0;
			collecting_q <= 1'b0;
			pos_q        <= 5'd0;
			status_q     <= sbusfr_pkg::LINK_TIMEOUT;
			age_q        <= 16'd0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					sbusfr_pkg::CFG_TIMEOUT: timeout_q <= cfg_data;
					sbusfr_pkg::CFG_END:     end_q     <= cfg_data[7:0];
				endcase
			end
			if (accept) begin
				if (is_tick) begin
					age_q <= age_next;
					if (tmo_hit) status_q <= sbusfr_pkg::LINK_TIMEOUT;
				end else if (!collecting_q) begin
					if (data_byte == sbusfr_pkg::START_BYTE) begin
						collecting_q <= 1'b1;
						pos_q        <= sbusfr_pkg::POS_FIRST;
					end
				end else if (in_range) begin
					pos_q <= pos_q + 5'd1;
				end else begin
					collecting_q <= 1'b0;
					pos_q        <= 5'd0;
					if (frame_ok) begin
						status_q <= frame_status;
						age_q    <= 16'd0;
					end
				end
			end
		end
	end

	// Frame bytes shift in from the top; byte 1 ends at the low end
	always_ff @(posedge clk) begin
		if (accept && !is_tick && collecting_q && in_range)
			store_q <= {data_byte, store_q[sbusfr_pkg::STORE_W-1:8]};
	end

	`SBUSFR_ASSERT(a_hunt_pos, !collecting_q |-> (pos_q == 5'd0), "position set while hunting")
	`SBUSFR_ASSERT(a_frame_age, (accept && !is_tick && frame_ok) |=> (age_q == 16'd0), "age not cleared")

endmodule

/* src/sbusfr_back.sv */
// ---------------------------------------------------------------------------
// sbusfr_back
// Unpacks one job per run into channel results held in an output register.
// ---------------------------------------------------------------------------
`include "sbus_frame_receiver_core_assert.svh"

module sbusfr_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_empty,
	input  sbusfr_pkg::job_t        q_head,
	output logic                    q_pop,
	input  logic                    pop,
	output logic                    empty,
	output logic [3:0]              channel_index,
	output logic [10:0]             channel_value,
	output logic                    digital_one,
	output logic                    digital_two,
	output logic                    lost_flag,
	output logic                    safe_flag,
	output logic [1:0]              link_status
,	output logic                    last_of_run
);

	sbusfr_pkg::job_t        job_q;
	logic                    active_q;
	logic [3:0]              cnt_q;
	logic                    out_valid_q;
	logic [3:0]              idx_q;
	logic [10:0]             value_q;
	logic [7:0]              flags_q;
	sbusfr_pkg::link_t       status_q;
	logic                    last_q;

	logic adv;
	logic emit;
	logic last;

	assign adv   = !out_valid_q || pop;
	assign emit  = active_q && adv;
	assign last  = job_q.is_timeout || (cnt_q == sbusfr_pkg::CHAN_LAST);
	assign q_pop = !active_q && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			cnt_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				active_q <= 1'b1;
				cnt_q    <= 4'd0;
			end else if (emit) begin
				cnt_q <= cnt_q + 4'd1;
				if (last) active_q <= 1'b0;
			end
			if (adv) out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_head;
		end else if (emit) begin
			job_q.chan_bits <= {{sbusfr_pkg::CHAN_W{1'b0}},
				job_q.chan_bits[sbusfr_pkg::DATA_W-1:sbusfr_pkg::CHAN_W]};
		end
		if (emit) begin
			idx_q    <= job_q.is_timeout ? 4'd0 : cnt_q;
			value_q  <= job_q.is_timeout ? 11'd0
				: (job_q.chan_bits[sbusfr_pkg::CHAN_W-1:0] & sbusfr_pkg::CHAN_MASK);
			flags_q  <= job_q.flags;
			status_q <= job_q.status;
			last_q   <= last;
		end
	end

	assign empty         = !out_valid_q;
	assign channel_index = idx_q;
	assign channel_value = value_q;
	assign digital_one   = flags_q[0];
	assign digital_two   = flags_q[1];
	assign lost_flag     = flags_q[2];
	assign safe_flag     = flags_q[3];
	assign link_status   = status_q;
	assign last_of_run   = last_q;

	`SBUSFR_ASSERT(a_tmo_shape, (out_valid_q && status_q == sbusfr_pkg::LINK_TIMEOUT) |-> (last_q && idx_q == 4'd0 && value_q == 11'd0), "bad timeout result")
	`SBUSFR_ASSERT(a_frame_last, (out_valid_q && status_q != sbusfr_pkg::LINK_TIMEOUT) |-> (last_q == (idx_q == sbusfr_pkg::CHAN_LAST)), "last mark misplaced")

endmodule

/* src/sbus_frame_receiver_core.sv */
// ---------------------------------------------------------------------------
// sbus_frame_receiver_core
// SBUS frame decoder: bytes and ticks in, channel results out.
// ---------------------------------------------------------------------------
// Usage:
//   Input queue side: drive action/data_byte and raise push; a transfer
//   happens on a rising edge with push high and full low. action 0 is a
//   received byte, action 1 is one elapsed time tick.
//   Result queue side: while empty is low the oldest result is on the
//   result ports; a transfer happens on a rising edge with pop high.
//   Configuration: cfg_we writes cfg_data to register cfg_index
//   (0 timeout_ticks, 1 end_marker) on the same edge; write only when idle.
//   Throughput: one input transfer per cycle while full is low. A valid
//   frame end byte yields 16 results, one per cycle when pop stays high,
//   and a timeout tick yields one result; each job passes the job queue,
//   the back end job register and the output register before it shows.
//   A two-entry job queue parts the front from the unpacking back end, so
//   full rises only when two jobs wait while the back end still unpacks.
//   Stalling pop holds the output register and then fills the job queue.
//   Reset: link status timeout, hunting for the start byte, tick age zero,
//   timeout_ticks 100, end_marker 0, no results pending.
// ---------------------------------------------------------------------------
module sbus_frame_receiver_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic        action,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [3:0]  channel_index,
	output logic [10:0] channel_value,
	output logic        digital_one,
	output logic        digital_two,
	output logic        lost_flag,
	output logic        safe_flag,
	output logic [1:0]  link_status,
	output logic        last_of_run
);

	logic             accept;
	logic             job_push;
	sbusfr_pkg::job_t job;
	sbusfr_pkg::job_t q_head;
	logic             q_empty;
	logic             q_pop;

	// Take an input item whenever the job queue has room
	assign accept = push && !full;

	sbusfr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.action    (action),
		.data_byte (data_byte),
		.job_push  (job_push),
		.job       (job)
	);

	sbusfr_job_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (job),
		.full     (full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	sbusfr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.pop           (pop),
		.empty         (empty),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.digital_one   (digital_one),
		.digital_two   (digital_two),
		.lost_flag     (lost_flag),
		.safe_flag     (safe_flag),
		.link_status   (link_status),
		.last_of_run   (last_of_run)
	);

endmodule
